FILE: design/dss_pkg.sv
// Shared types, constants and helpers for the dispense station sequencer.
// Used by dss_station, dispense_station_sequencer_unit, dss_checker and testbench; no dependencies.
package dss_pkg;

    // Field and bus widths
    localparam int FIELD_W    = 3;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 8;   // 6 used bits, padded to a byte
    localparam int OUT_DATA_W = 16;  // 12 used bits, padded to two bytes
    localparam int STATIONS_DEFAULT = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_WATER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_FLOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUP_IN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUP_OUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AFTER_DRAW = 3'd4;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] RST_WAIT_WATER = 8'd22;
    localparam logic [CNT_W-1:0] RST_NO_FLOW    = 8'd28;
    localparam logic [CNT_W-1:0] RST_CUP_IN     = 8'd3;
    localparam logic [CNT_W-1:0] RST_CUP_OUT    = 8'd5;
    localparam logic [CNT_W-1:0] RST_AFTER_DRAW = 8'd6;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Station phase
    typedef enum logic [1:0] {
        PH_WAITING = 2'd0,
        PH_RUNNING = 2'd1,
        PH_ENDING  = 2'd2,
        PH_AFTER   = 2'd3
    } phase_t;

    // Configuration seen by every station
    typedef struct packed {
        logic [CNT_W-1:0] wait_water_ticks;
        logic [CNT_W-1:0] no_flow_ticks;
        logic [CNT_W-1:0] cup_in_ticks;
        logic [CNT_W-1:0] cup_out_ticks;
        logic [CNT_W-1:0] after_draw_ticks;
    } cfg_t;

    // Per-station result bits of one tick
    typedef struct packed {
        logic pump;
        logic drain;
        logic red;
        logic green;
    } st_out_t;

    // Saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

FILE: design/dss_station.sv
// One dispense station: phase register, counters and lamp/pump flags.
// Computes one scan tick combinationally and updates its state on en.
// Depends on dss_pkg.
module dss_station (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          cup,
    input  logic          water,
    input  dss_pkg::cfg_t cfg,
    output dss_pkg::st_out_t res
);
    import dss_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] dry_reg, dry_next;
    logic [CNT_W-1:0] cin_reg, cin_next;
    logic [CNT_W-1:0] cout_reg, cout_next;
    logic             flow_reg, flow_next;
    logic             cp_reg, cp_next;
    logic             pump_reg, pump_next;
    logic             red_reg, red_next;
    logic             green_reg, green_next;
    logic             drain;

    // One tick: phases entered during the tick are evaluated in the same tick, except a return to waiting
    always_comb
    begin
        logic placed;
        logic removed;
        logic stop;
        phase_next = phase_reg;
        scan_next  = sat_inc(scan_reg);
        dry_next   = dry_reg;
        cin_next   = cin_reg;
        cout_next  = cout_reg;
        flow_next  = flow_reg;
        cp_next    = cp_reg;
        pump_next  = pump_reg;
        red_next   = red_reg;
        green_next = green_reg;
        drain      = 1'b0;
        placed     = 1'b0;
        removed    = 1'b0;
        stop       = 1'b0;

        // Waiting for a counted cup
        if (phase_next == PH_WAITING)
        begin
            green_next = 1'b1;
            if (cup)
            begin
                cin_next = sat_inc(cin_next);
                if (cin_next >= cfg.cup_in_ticks)
                begin
                    cin_next = '0;
                    placed   = 1'b1;
                end
            end
            if (placed)
            begin
                phase_next = PH_RUNNING;
                green_next = 1'b0;
                scan_next  = '0;
                cp_next    = 1'b0;
            end
        end

        // Pumping: no-flow checkpoint and cup removal
        if (phase_next == PH_RUNNING)
        begin
            red_next  = 1'b1;
            pump_next = 1'b1;
            if (scan_next >= cfg.wait_water_ticks && !cp_next)
            begin
                scan_next = '0;
                cp_next   = 1'b1;
            end
            if (!water)
            begin
                dry_next = sat_inc(dry_next);
                if (dry_next >= cfg.no_flow_ticks)
                begin
                    flow_next = 1'b0;
                    dry_next  = '0;
                end
            end
            else
            begin
                flow_next = 1'b1;
                dry_next  = '0;
            end
            if (!flow_next && cp_next)
            begin
                stop = 1'b1;
            end
            else if (!cup)
            begin
                // removal counter only advances when consulted
                cout_next = sat_inc(cout_next);
                if (cout_next >= cfg.cup_out_ticks)
                begin
                    cout_next = '0;
                    stop      = 1'b1;
                end
            end
            if (stop)
            begin
                cp_next    = 1'b1;
                phase_next = PH_ENDING;
                red_next   = 1'b0;
                pump_next  = 1'b0;
                drain      = 1'b1;
            end
            else
            begin
                cp_next = 1'b0;
            end
        end

        // Stopped: blink until the cup is taken away
        if (phase_next == PH_ENDING)
        begin
            cp_next    = 1'b0;
            green_next = ~green_next;
            red_next   = ~red_next;
            if (!cup)
            begin
                cout_next = sat_inc(cout_next);
                if (cout_next >= cfg.cup_out_ticks)
                begin
                    cout_next = '0;
                    removed   = 1'b1;
                end
            end
            if (removed)
            begin
                phase_next = PH_AFTER;
                red_next   = 1'b0;
                green_next = 1'b0;
                scan_next  = '0;
            end
        end

        // After-draw pump run
        if (phase_next == PH_AFTER)
        begin
            if (scan_next <= cfg.after_draw_ticks)
            begin
                red_next  = ~red_next;
                pump_next = 1'b1;
            end
            else
            begin
                red_next   = 1'b0;
                green_next = 1'b0;
                pump_next  = 1'b0;
                phase_next = PH_WAITING;
                scan_next  = '0;
            end
        end
    end

    // Result bits of this tick
    always_comb
    begin
        res.pump  = pump_next;
        res.drain = drain;
        res.red   = red_next;
        res.green = green_next;
    end

    // State update on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAITING;
            scan_reg  <= '0;
            dry_reg   <= '0;
            cin_reg   <= '0;
            cout_reg  <= '0;
            flow_reg  <= 1'b1;
            cp_reg    <= 1'b0;
            pump_reg  <= 1'b0;
            red_reg   <= 1'b0;
            green_reg <= 1'b0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            scan_reg  <= scan_next;
            dry_reg   <= dry_next;
            cin_reg   <= cin_next;
            cout_reg  <= cout_next;
            flow_reg  <= flow_next;
            cp_reg    <= cp_next;
            pump_reg  <= pump_next;
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

endmodule

FILE: design/dispense_station_sequencer_unit.sv
// Dispense station sequencer top level: stream ports, config registers,
// station instances and the result register. Depends on dss_pkg, dss_station.
// Latency: the result of an item is valid the cycle after it is accepted.
// Throughput: one item per cycle; the single result register decouples the
// two sides, so an item is taken whenever the result slot is free or drains.
// Reset (rst_n, async, active low): all stations waiting, config at defaults.
module dispense_station_sequencer_unit #(
    parameter int STATIONS = dss_pkg::STATIONS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Scan ticks: [2:0] cup_levels, [5:3] water_levels, [7:6] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dss_pkg::IN_DATA_W-1:0]     s_tdata,
    // Results: [2:0] pump_request, [5:3] drain_pulse, [8:6] red_lamp,
    // [11:9] green_lamp, [15:12] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dss_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dss_pkg::CNT_W-1:0]         cfg_data
);
    import dss_pkg::*;

    // Only stations that have sensor and result bits take part
    localparam int NUM_ST = (STATIONS < FIELD_W) ? STATIONS : FIELD_W;

    cfg_t                  cfg_reg;
    logic                  accept;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [FIELD_W-1:0]    cup_levels;
    logic [FIELD_W-1:0]    water_levels;
    logic [FIELD_W-1:0]    pump_request;
    logic [FIELD_W-1:0]    drain_pulse;
    logic [FIELD_W-1:0]    red_lamp;
    logic [FIELD_W-1:0]    green_lamp;
    st_out_t               st_res [NUM_ST];

    assign cup_levels   = s_tdata[FIELD_W-1:0];
    assign water_levels = s_tdata[2*FIELD_W-1:FIELD_W];

    // Handshake
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_water_ticks <= RST_WAIT_WATER;
            cfg_reg.no_flow_ticks    <= RST_NO_FLOW;
            cfg_reg.cup_in_ticks     <= RST_CUP_IN;
            cfg_reg.cup_out_ticks    <= RST_CUP_OUT;
            cfg_reg.after_draw_ticks <= RST_AFTER_DRAW;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WAIT_WATER: cfg_reg.wait_water_ticks <= cfg_data;
                REG_NO_FLOW:    cfg_reg.no_flow_ticks    <= cfg_data;
                REG_CUP_IN:     cfg_reg.cup_in_ticks     <= cfg_data;
                REG_CUP_OUT:    cfg_reg.cup_out_ticks    <= cfg_data;
                REG_AFTER_DRAW: cfg_reg.after_draw_ticks <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Station instances
    for (genvar i = 0; i < NUM_ST; i++)
    begin : g_st
        dss_station u_station (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (accept),
            .cup   (cup_levels[i]),
            .water (water_levels[i]),
            .cfg   (cfg_reg),
            .res   (st_res[i])
        );
    end

    // Gather per-station bits; unused stations read as zero
    always_comb
    begin
        pump_request = '0;
        drain_pulse  = '0;
        red_lamp     = '0;
        green_lamp   = '0;
        for (int i = 0; i < NUM_ST; i++)
        begin
            pump_request[i] = st_res[i].pump;
            drain_pulse[i]  = st_res[i].drain;
            red_lamp[i]     = st_res[i].red;
            green_lamp[i]   = st_res[i].green;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {{(OUT_DATA_W - 4*FIELD_W){1'b0}},
                            green_lamp, red_lamp, drain_pulse, pump_request};
        end
    end

endmodule

FILE: verif/dss_checker.sv
`timescale 1ns / 1ps
// Checker for the dispense station sequencer: watches the scan, result and
// configuration channels, predicts each tick's result and compares it.
// Depends on dss_pkg for widths, register indexes, reset values and phases.
module dss_checker #(
    parameter int STATIONS = dss_pkg::STATIONS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [dss_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dss_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dss_pkg::CNT_W-1:0]      cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import dss_pkg::*;

    // One tick's lamp and pump word, high field first as on m_tdata
    typedef struct packed {
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] drain;
        logic [FIELD_W-1:0] pump;
    } lamp_word_t;

    // Shadow of the configuration registers
    cfg_t cfg_copy;

    // Per-station sequencer state
    phase_t           st_phase [STATIONS];
    logic [CNT_W-1:0] st_scan  [STATIONS];
    logic [CNT_W-1:0] st_dry   [STATIONS];
    logic [CNT_W-1:0] st_cin   [STATIONS];
    logic [CNT_W-1:0] st_cout  [STATIONS];
    logic             st_flow  [STATIONS];
    logic             st_ckpt  [STATIONS];
    logic             st_pump  [STATIONS];
    logic             st_red   [STATIONS];
    logic             st_green [STATIONS];

    lamp_word_t pending_words[$];
    lamp_word_t got_word;
    lamp_word_t want_word;

    function automatic logic [CNT_W-1:0] bump8(input logic [CNT_W-1:0] v);
        bump8 = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Counted cup placement; the count survives low ticks
    function automatic logic cup_arrived(input int s, input logic cup);
        cup_arrived = 1'b0;
        if (cup)
        begin
            st_cin[s] = bump8(st_cin[s]);
            if (st_cin[s] >= cfg_copy.cup_in_ticks)
            begin
                st_cin[s] = '0;
                cup_arrived = 1'b1;
            end
        end
    endfunction

    // Counted cup removal; the count survives high ticks
    function automatic logic cup_gone(input int s, input logic cup);
        cup_gone = 1'b0;
        if (!cup)
        begin
            st_cout[s] = bump8(st_cout[s]);
            if (st_cout[s] >= cfg_copy.cup_out_ticks)
            begin
                st_cout[s] = '0;
                cup_gone = 1'b1;
            end
        end
    endfunction

    // Advance every station by one scan tick and build its result word
    function automatic lamp_word_t predict_tick(input logic [FIELD_W-1:0] cup,
                                                input logic [FIELD_W-1:0] water);
        lamp_word_t w;
        phase_t     ph;
        logic       stop;
        int         s;
        w = '0;
        for (s = 0; s < STATIONS; s++)
        begin
            ph = st_phase[s];
            st_scan[s] = bump8(st_scan[s]);

            if (ph == PH_WAITING)
            begin
                st_green[s] = 1'b1;
                if (cup_arrived(s, cup[s]))
                begin
                    ph = PH_RUNNING;
                    st_green[s] = 1'b0;
                    st_scan[s] = '0;
                    st_ckpt[s] = 1'b0;
                end
            end

            if (ph == PH_RUNNING)
            begin
                st_red[s] = 1'b1;
                st_pump[s] = 1'b1;
                if (st_scan[s] >= cfg_copy.wait_water_ticks && !st_ckpt[s])
                begin
                    st_scan[s] = '0;
                    st_ckpt[s] = 1'b1;
                end
                if (!water[s])
                begin
                    st_dry[s] = bump8(st_dry[s]);
                    if (st_dry[s] >= cfg_copy.no_flow_ticks)
                    begin
                        st_flow[s] = 1'b0;
                        st_dry[s] = '0;
                    end
                end
                else
                begin
                    st_flow[s] = 1'b1;
                    st_dry[s] = '0;
                end
                // removal count only moves when the no-flow test fails
                stop = !st_flow[s] && st_ckpt[s];
                if (!stop)
                    stop = cup_gone(s, cup[s]);
                if (stop)
                begin
                    st_ckpt[s] = 1'b1;
                    ph = PH_ENDING;
                    st_red[s] = 1'b0;
                    st_pump[s] = 1'b0;
                    w.drain[s] = 1'b1;
                end
                else
                    st_ckpt[s] = 1'b0;
            end

            if (ph == PH_ENDING)
            begin
                st_ckpt[s] = 1'b0;
                st_green[s] = !st_green[s];
                st_red[s] = !st_red[s];
                if (cup_gone(s, cup[s]))
                begin
                    ph = PH_AFTER;
                    st_red[s] = 1'b0;
                    st_green[s] = 1'b0;
                    st_scan[s] = '0;
                end
            end

            if (ph == PH_AFTER)
            begin
                if (st_scan[s] <= cfg_copy.after_draw_ticks)
                begin
                    st_red[s] = !st_red[s];
                    st_pump[s] = 1'b1;
                end
                else
                begin
                    st_red[s] = 1'b0;
                    st_green[s] = 1'b0;
                    st_pump[s] = 1'b0;
                    ph = PH_WAITING;
                    st_scan[s] = '0;
                end
            end

            st_phase[s] = ph;
            w.pump[s] = st_pump[s];
            w.red[s] = st_red[s];
            w.green[s] = st_green[s];
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
                                   input logic [OUT_DATA_W-1:0] want);
        $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [FIELD_W-1:0] got,
                               input logic [FIELD_W-1:0] want);
        if (got !== want)
            report_mismatch(what, OUT_DATA_W'(got), OUT_DATA_W'(want));
    endtask

    // Channel monitor: config writes, accepted ticks, accepted results
    always @(posedge clk or negedge rst_n)
    begin : monitor
        int s;
        if (!rst_n)
        begin
            cfg_copy.wait_water_ticks = RST_WAIT_WATER;
            cfg_copy.no_flow_ticks    = RST_NO_FLOW;
            cfg_copy.cup_in_ticks     = RST_CUP_IN;
            cfg_copy.cup_out_ticks    = RST_CUP_OUT;
            cfg_copy.after_draw_ticks = RST_AFTER_DRAW;
            for (s = 0; s < STATIONS; s++)
            begin
                st_phase[s] = PH_WAITING;
                st_scan[s]  = '0;
                st_dry[s]   = '0;
                st_cin[s]   = '0;
                st_cout[s]  = '0;
                st_flow[s]  = 1'b1;
                st_ckpt[s]  = 1'b0;
                st_pump[s]  = 1'b0;
                st_red[s]   = 1'b0;
                st_green[s] = 1'b0;
            end
            pending_words.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WAIT_WATER: cfg_copy.wait_water_ticks = cfg_data;
                    REG_NO_FLOW:    cfg_copy.no_flow_ticks    = cfg_data;
                    REG_CUP_IN:     cfg_copy.cup_in_ticks     = cfg_data;
                    REG_CUP_OUT:    cfg_copy.cup_out_ticks    = cfg_data;
                    REG_AFTER_DRAW: cfg_copy.after_draw_ticks = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                pending_words.push_back(predict_tick(s_tdata[FIELD_W-1:0],
                                                     s_tdata[2*FIELD_W-1:FIELD_W]));

            if (m_tvalid && m_tready)
            begin
                if (pending_words.size() == 0)
                    report_mismatch("result with no tick waiting", m_tdata, '0);
                else
                begin
                    want_word = pending_words.pop_front();
                    got_word = m_tdata[4*FIELD_W-1:0];
                    check_field("pump_request", got_word.pump, want_word.pump);
                    check_field("drain_pulse", got_word.drain, want_word.drain);
                    check_field("red_lamp", got_word.red, want_word.red);
                    check_field("green_lamp", got_word.green, want_word.green);
                    if (m_tdata[OUT_DATA_W-1:4*FIELD_W] !== '0)
                        report_mismatch("padding", m_tdata, '0);
                end
            end
            outstanding = pending_words.size();
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the dispense station sequencer testbench: clock, reset, scan tick,
// result and config stimulus, watchdog and verdict. Depends on dss_pkg,
// dispense_station_sequencer_unit and dss_checker.
module testbench;
    import dss_pkg::*;

    localparam int STATIONS       = STATIONS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int SETTLE_CYCLES  = 4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CNT_W-1:0]      cfg_data = '0;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;

    // Burst modes: stretches with no idling on either side
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;

    // Per-station cup and water run generator
    logic [FIELD_W-1:0] cup_lvl = '0;
    logic [FIELD_W-1:0] water_lvl = '1;
    int cup_left[STATIONS];
    int water_left[STATIONS];
    int cup_span = 8;
    int water_span = 8;

    always #10 clk = ~clk;

    dispense_station_sequencer_unit #(.STATIONS(STATIONS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dss_checker #(.STATIONS(STATIONS)) CHK (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // Watchdog: ends the run after too many cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result sink with a random stall before each item outside burst mode
    initial
    begin : result_sink
        int stall;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 59) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // One scan tick; returns at the falling edge after it was taken
    task automatic send_tick(input logic [FIELD_W-1:0] cup, input logic [FIELD_W-1:0] water);
        int gap;
        if ($urandom_range(0, 59) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata <= {{(IN_DATA_W - 2 * FIELD_W){1'b0}}, water, cup};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender until every predicted result is back, then settle
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // New register setting, written only while the block is idle
    task automatic program_phase(input logic [CNT_W-1:0] wait_w, input logic [CNT_W-1:0] no_flow,
                                 input logic [CNT_W-1:0] cup_in, input logic [CNT_W-1:0] cup_out,
                                 input logic [CNT_W-1:0] after_d);
        logic [CFG_IDX_W-1:0] spare_idx;
        wait_until_drained();
        write_reg(REG_WAIT_WATER, wait_w);
        write_reg(REG_NO_FLOW, no_flow);
        write_reg(REG_CUP_IN, cup_in);
        write_reg(REG_CUP_OUT, cup_out);
        write_reg(REG_AFTER_DRAW, after_d);
        // an index past the last register must leave everything alone
        spare_idx = CFG_IDX_W'(REG_AFTER_DRAW + 1 + $urandom_range(0, 2));
        write_reg(spare_idx, CNT_W'($urandom));
        cup_span = ((cup_in > cup_out) ? cup_in : cup_out) + 3;
        water_span = no_flow + wait_w + 3;
    endtask

    // Cup placed/removed and wet/dry runs per station, with some noise
    task automatic make_levels(output logic [FIELD_W-1:0] cup, output logic [FIELD_W-1:0] water);
        logic [2*FIELD_W-1:0] lv;
        int s;
        for (s = 0; s < STATIONS; s++)
        begin
            if (cup_left[s] <= 0)
            begin
                if ($urandom_range(0, 4) != 0)
                    cup_lvl[s] = !cup_lvl[s];
                else
                    cup_lvl[s] = 1'($urandom_range(0, 1));
                cup_left[s] = $urandom_range(1, cup_span);
            end
            cup_left[s]--;
            if (water_left[s] <= 0)
            begin
                water_lvl[s] = ($urandom_range(0, 9) < 6);
                water_left[s] = $urandom_range(1, water_span);
            end
            water_left[s]--;
        end
        lv = {water_lvl, cup_lvl};
        if ($urandom_range(0, 19) == 0)
            lv[$urandom_range(0, 2 * FIELD_W - 1)] ^= 1'b1;
        else if ($urandom_range(0, 39) == 0)
            lv = (2 * FIELD_W)'($urandom);
        cup = lv[FIELD_W-1:0];
        water = lv[2*FIELD_W-1:FIELD_W];
    endtask

    task automatic run_random(input int count);
        logic [FIELD_W-1:0] cup;
        logic [FIELD_W-1:0] water;
        int n;
        for (n = 0; n < count; n++)
        begin
            make_levels(cup, water);
            send_tick(cup, water);
            if ($urandom_range(0, 199) == 0)
                wait_until_drained();
        end
    endtask

    initial
    begin : stimulus
        int p;
        int s;
        for (s = 0; s < STATIONS; s++)
        begin
            cup_left[s] = 0;
            water_left[s] = 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one full draw at reset settings, all stations together
        send_tick(3'b000, 3'b000);
        repeat (4) send_tick(3'b111, 3'b111);
        repeat (2) send_tick(3'b111, 3'b000);
        repeat (5) send_tick(3'b000, 3'b111);
        repeat (5) send_tick(3'b000, 3'b000);
        repeat (4) send_tick(3'b000, 3'b111);
        repeat (2) send_tick(3'b101, 3'b010);

        // Every register at zero: detection, stop and removal on first tick
        program_phase('0, '0, '0, '0, '0);
        run_random(120);

        // Every register at the top: the scan counter saturates, after-draw never ends
        program_phase(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
        run_random(300);

        // Short draws that end stuck in after-draw
        program_phase(CNT_W'($urandom_range(1, 4)), CNT_W'($urandom_range(1, 4)),
                      CNT_W'($urandom_range(1, 4)), CNT_W'($urandom_range(1, 4)), CNT_MAX);
        run_random(100);

        // Small random settings, one phase mixing both extremes
        for (p = 0; p < 8; p++)
        begin
            if (p == 5)
                program_phase($urandom_range(0, 1) ? CNT_MAX : '0,
                              $urandom_range(0, 1) ? CNT_MAX : '0,
                              $urandom_range(0, 1) ? 8'd1 : '0,
                              $urandom_range(0, 1) ? 8'd1 : '0,
                              $urandom_range(0, 1) ? 8'd2 : '0);
            else
                program_phase(CNT_W'($urandom_range(0, 10)), CNT_W'($urandom_range(0, 10)),
                              CNT_W'($urandom_range(0, 10)), CNT_W'($urandom_range(0, 10)),
                              CNT_W'($urandom_range(0, 10)));
            run_random(100);
        end

        wait_until_drained();
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
